@@ sv/rawt_pkg.sv @@
// Shared types and command codes of the resource allocator.
package rawt_pkg;

	localparam int CmdW = 2;
	localparam int ClientW = 5;
	localparam int TicksW = 8;
	localparam int ResW = 4;

	typedef enum logic [CmdW-1:0] {
		CMD_REQUEST = 2'd0,
		CMD_RELEASE = 2'd1,
		CMD_TICK    = 2'd2,
		CMD_NONE    = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t               cmd;
		logic [ClientW-1:0] client;
		logic [TicksW-1:0]  wait_ticks;
		logic [ResW-1:0]    resource;
	} req_t;

	typedef struct packed {
		logic [ClientW-1:0] client_res;
		logic [ResW-1:0]    granted_resource;
		logic               status;
		logic               last;
	} res_t;

endpackage

@@ sv/resource_allocator_with_timeouts.sv @@
// Top level of the resource allocator with wait timeouts.
// The result of a grant or a hand-over on release is registered at the output.
// A tick sweeps every client slot in turn, pausing while the output is full, and
// rescans the last slot if it and an earlier one time out; results go out as found.
// Throughput: one request or release per cycle while idle and results are taken.
// The queue, the busy pool and all wait slots clear on reset; counters do not.
module resource_allocator_with_timeouts #(
	parameter int CLIENTS = 32,
	parameter int RESOURCES = 16,
	parameter int COUNT_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata, // client, wait_ticks, resource
	input  logic [1:0]  s_tuser, // cmd
	input  logic        m_tready,
	output logic        m_tvalid,
	output logic [15:0] m_tdata, // client_res, granted_resource
	output logic        m_tuser, // status
	output logic        m_tlast
);
	rawt_pkg::req_t in_req, q_req;
	rawt_pkg::res_t o_res;
	logic q_valid, q_ready;

	assign in_req.cmd = rawt_pkg::cmd_t'(s_tuser);
	assign in_req.client = s_tdata[4:0];
	assign in_req.wait_ticks = s_tdata[12:5];
	assign in_req.resource = s_tdata[16:13];

	rawt_front #(.CLIENTS(CLIENTS), .RESOURCES(RESOURCES), .DEPTH(2)) u_front (
		.clk, .arst_n, .in_valid(s_tvalid), .in_ready(s_tready), .in_req,
		.q_valid, .q_ready, .q_req
	);

	rawt_back #(.CLIENTS(CLIENTS), .RESOURCES(RESOURCES), .COUNT_BITS(COUNT_BITS)) u_back (
		.clk, .arst_n, .q_valid, .q_ready, .q_req,
		.out_valid(m_tvalid), .out_ready(m_tready), .out_res(o_res)
	);

	assign m_tdata = {7'd0, o_res.granted_resource, o_res.client_res};
	assign m_tuser = o_res.status;
	assign m_tlast = o_res.last;

endmodule

@@ sv/rawt_front.sv @@
// Input side: accepts requests, drops meaningless ones and queues the rest.
module rawt_front #(
	parameter int CLIENTS = 32,
	parameter int RESOURCES = 16,
	parameter int DEPTH = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  rawt_pkg::req_t  in_req,
	output logic            q_valid,
	input  logic            q_ready,
	output rawt_pkg::req_t  q_req
);
	localparam int PW = $clog2(DEPTH);

	rawt_pkg::req_t mem_q [DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [PW:0] cnt_q;
	logic keep, push, pop;

	always_comb begin
		keep = 1'b0;
		unique case (in_req.cmd)
			rawt_pkg::CMD_REQUEST: keep = 32'(in_req.client) < CLIENTS;
			rawt_pkg::CMD_RELEASE: keep = (in_req.resource != '0) &&
				(32'(in_req.resource) < RESOURCES);
			rawt_pkg::CMD_TICK: keep = 1'b1;
			default: keep = 1'b0;
		endcase
	end

	assign in_ready = cnt_q != (PW+1)'(DEPTH);
	assign push = in_valid && in_ready && keep;
	assign q_valid = cnt_q != '0;
	assign pop = q_valid && q_ready;
	assign q_req = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= in_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (32'(wp_q) == DEPTH-1) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (32'(rp_q) == DEPTH-1) ? '0 : rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end

endmodule

@@ sv/rawt_back.sv @@
// Execution side: pool and wait state, grants, hand-overs and timeout sweep.
module rawt_back #(
	parameter int CLIENTS = 32,
	parameter int RESOURCES = 16,
	parameter int COUNT_BITS = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	output logic            q_ready,
	input  rawt_pkg::req_t  q_req,
	output logic            out_valid,
	input  logic            out_ready,
	output rawt_pkg::res_t  out_res
);
	localparam int CW = $clog2(CLIENTS);
	localparam int RW = $clog2(RESOURCES);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_TICK = 2'b10
	} state_t;

	state_t state_q;
	logic [RESOURCES-1:0] busy_q;
	logic [CLIENTS-1:0] wait_q;
	logic [COUNT_BITS-1:0] count_q [CLIENTS];
	logic [CW-1:0] scan_q;
	logic have_q;
	rawt_pkg::res_t held_q;
	logic ovalid_q;
	rawt_pkg::res_t ores_q;

	logic slot_free;
	logic free_found, wait_found;
	logic [RW-1:0] free_idx;
	logic [CW-1:0] wait_idx;
	logic [RW-1:0] rel_idx;
	logic scan_last, scan_exp;

	assign slot_free = !ovalid_q || out_ready;
	assign out_valid = ovalid_q;
	assign out_res = ores_q;
	assign rel_idx = RW'(q_req.resource);

	always_comb begin
		free_found = 1'b0;
		free_idx = '0;
		for (int r = RESOURCES-1; r >= 1; r--) begin
			if (!busy_q[r]) begin
				free_found = 1'b1;
				free_idx = RW'(r);
			end
		end
		wait_found = 1'b0;
		wait_idx = '0;
		for (int c = CLIENTS-1; c >= 0; c--) begin
			if (wait_q[c]) begin
				wait_found = 1'b1;
				wait_idx = CW'(c);
			end
		end
	end

	assign scan_last = 32'(scan_q) == CLIENTS-1;
	assign scan_exp = wait_q[scan_q] && (count_q[scan_q] == '0);
	assign q_ready = (state_q == ST_IDLE) && slot_free;

	always_ff @(posedge clk) begin
		if (q_valid && q_ready && q_req.cmd == rawt_pkg::CMD_REQUEST && !free_found) begin
			count_q[CW'(q_req.client)] <= COUNT_BITS'(q_req.wait_ticks);
		end else if (state_q == ST_TICK && slot_free && wait_q[scan_q] && !scan_exp) begin
			count_q[scan_q] <= count_q[scan_q] - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q <= '0;
			wait_q <= '0;
			scan_q <= '0;
			have_q <= 1'b0;
			held_q <= '0;
			ovalid_q <= 1'b0;
			ores_q <= '0;
		end else begin
			if (ovalid_q && out_ready) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid && q_ready) begin
						priority case (q_req.cmd)
							rawt_pkg::CMD_REQUEST: begin
								if (free_found) begin
									busy_q[free_idx] <= 1'b1;
									wait_q[CW'(q_req.client)] <= 1'b0;
									ovalid_q <= 1'b1;
									ores_q <= '{q_req.client, 4'(free_idx), 1'b0, 1'b1};
								end else begin
									wait_q[CW'(q_req.client)] <= 1'b1;
								end
							end
							rawt_pkg::CMD_RELEASE: begin
								if (busy_q[rel_idx]) begin
									if (wait_found) begin
										wait_q[wait_idx] <= 1'b0;
										ovalid_q <= 1'b1;
										ores_q <= '{5'(wait_idx), q_req.resource, 1'b0, 1'b1};
									end else begin
										busy_q[rel_idx] <= 1'b0;
									end
								end
							end
							default: begin
								scan_q <= '0;
								have_q <= 1'b0;
								state_q <= ST_TICK;
							end
						endcase
					end
				end
				ST_TICK: begin
					if (slot_free) begin
						if (scan_exp) begin
							wait_q[scan_q] <= 1'b0;
							if (have_q) begin
								ovalid_q <= 1'b1;
								ores_q <= held_q;
							end
							have_q <= 1'b1;
							held_q <= '{5'(scan_q), 4'd0, 1'b1, 1'b0};
						end
						if (scan_last) begin
							if (have_q || scan_exp) begin
								state_q <= ST_IDLE;
							end else begin
								state_q <= ST_IDLE;
							end
						end else begin
							scan_q <= scan_q + 1'b1;
						end
					end
					if (slot_free && scan_last && have_q && !scan_exp) begin
						ovalid_q <= 1'b1;
						ores_q <= '{held_q.client_res, 4'd0, 1'b1, 1'b1};
					end
					if (slot_free && scan_last && scan_exp && !have_q) begin
						ovalid_q <= 1'b1;
						ores_q <= '{5'(scan_q), 4'd0, 1'b1, 1'b1};
						have_q <= 1'b0;
					end
					if (slot_free && scan_last && scan_exp && have_q) begin
						state_q <= ST_TICK;
						scan_q <= scan_q;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (state_q == ST_TICK && slot_free && scan_last && !scan_exp && !have_q) begin
				state_q <= ST_IDLE;
			end
		end
	end

endmodule

@@ sv/rawt_checker.sv @@
// Port checker for the resource allocator, bound to the top level.
module rawt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic        m_tuser,
	input logic        m_tlast
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");
	a_grant_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tlast)
		else $error("grant not marked last");
	a_timeout_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[8:5] == 4'd0)
		else $error("timeout carries a resource");
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[15:9] == 7'd0)
		else $error("padding not zero");
endmodule

bind resource_allocator_with_timeouts rawt_checker u_rawt_checker (.*);

@@ tb/tb.sv @@
// Self-checking testbench for the resource allocator with wait timeouts.
`timescale 1ns / 100ps

module tb;

	localparam int NCLIENT = 32;
	localparam int NRES = 16;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		logic [rawt_pkg::ClientW-1:0] client;
		logic [rawt_pkg::ResW-1:0] granted;
		logic status;
		logic last;
	} alloc_result_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [23:0] s_tdata;
	logic [1:0] s_tuser;
	logic m_tready;
	logic m_tvalid;
	logic [15:0] m_tdata;
	logic m_tuser;
	logic m_tlast;

	bit pool_busy[NRES];
	bit slot_waiting[NCLIENT];
	logic [rawt_pkg::TicksW-1:0] slot_count[NCLIENT];
	alloc_result_t pending_results[$];
	int error_count;
	int cycle_count;
	int hold_cycles;

	resource_allocator_with_timeouts DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tready(m_tready),
		.m_tvalid(m_tvalid),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic alloc_result_t make_result(int c, int r, bit st, bit lst);
		alloc_result_t x;
		x.client = c[rawt_pkg::ClientW-1:0];
		x.granted = r[rawt_pkg::ResW-1:0];
		x.status = st;
		x.last = lst;
		return x;
	endfunction

	// Updates the pool and wait slots and queues the results a request causes.
	task automatic predict_allocation(rawt_pkg::cmd_t cmd, int c, int ticks, int r);
		int first_wait;
		int n;
		alloc_result_t x;
		case (cmd)
			rawt_pkg::CMD_REQUEST: begin
				for (int i = 1; i < NRES; i++) begin
					if (!pool_busy[i]) begin
						pool_busy[i] = 1'b1;
						slot_waiting[c] = 1'b0;
						pending_results.push_back(make_result(c, i, 1'b0, 1'b1));
						return;
					end
				end
				slot_count[c] = ticks[rawt_pkg::TicksW-1:0];
				slot_waiting[c] = 1'b1;
			end
			rawt_pkg::CMD_RELEASE: begin
				if (r == 0 || !pool_busy[r]) return;
				first_wait = -1;
				for (int i = 0; i < NCLIENT; i++)
					if (slot_waiting[i] && first_wait < 0) first_wait = i;
				if (first_wait >= 0) begin
					slot_waiting[first_wait] = 1'b0;
					pending_results.push_back(make_result(first_wait, r, 1'b0, 1'b1));
				end else begin
					pool_busy[r] = 1'b0;
				end
			end
			rawt_pkg::CMD_TICK: begin
				n = 0;
				for (int i = 0; i < NCLIENT; i++) begin
					if (slot_waiting[i]) begin
						if (slot_count[i] == 0) begin
							slot_waiting[i] = 1'b0;
							pending_results.push_back(make_result(i, 0, 1'b1, 1'b0));
							n++;
						end else begin
							slot_count[i] = slot_count[i] - 1'b1;
						end
					end
				end
				if (n > 0) begin
					x = pending_results.pop_back();
					x.last = 1'b1;
					pending_results.push_back(x);
				end
			end
			default: ;
		endcase
	endtask

	task automatic send_request(rawt_pkg::cmd_t cmd, int c, int ticks, int r);
		rawt_pkg::req_t item;
		item.cmd = cmd;
		item.client = c[rawt_pkg::ClientW-1:0];
		item.wait_ticks = ticks[rawt_pkg::TicksW-1:0];
		item.resource = r[rawt_pkg::ResW-1:0];
		s_tvalid <= 1'b1;
		s_tdata <= {7'd0, item.resource, item.wait_ticks, item.client};
		s_tuser <= item.cmd;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_allocation(cmd, c, ticks, r);
	endtask

	task automatic send_gap();
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
		if (gap > 0) s_tvalid <= 1'b0;
		repeat (gap) @(posedge clk);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (NCLIENT + 8) @(posedge clk);
	endtask

	task automatic send_random(int count, int req_weight);
		int pick;
		int burst;
		burst = 0;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < req_weight)
				send_request(rawt_pkg::CMD_REQUEST, $urandom_range(0, 31),
					($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
						: $urandom_range(0, 4), $urandom_range(0, 15));
			else if (pick < req_weight + 30)
				send_request(rawt_pkg::CMD_RELEASE, $urandom_range(0, 31),
					$urandom_range(0, 255), $urandom_range(0, 15));
			else if (pick < 97)
				send_request(rawt_pkg::CMD_TICK, $urandom_range(0, 31),
					$urandom_range(0, 255), $urandom_range(0, 15));
			else
				send_request(rawt_pkg::CMD_NONE, $urandom_range(0, 31),
					$urandom_range(0, 255), $urandom_range(0, 15));
			if (burst == 0) begin
				send_gap();
				burst = $urandom_range(1, 12);
			end else begin
				burst--;
			end
		end
	endtask

	task automatic test_directed();
		for (int i = 1; i < NRES; i++) send_request(rawt_pkg::CMD_REQUEST, i, 0, 0);
		send_request(rawt_pkg::CMD_REQUEST, 31, 255, 15);
		send_request(rawt_pkg::CMD_REQUEST, 0, 0, 0);
		send_request(rawt_pkg::CMD_REQUEST, 5, 1, 0);
		send_request(rawt_pkg::CMD_REQUEST, 5, 2, 0);
		send_request(rawt_pkg::CMD_TICK, 31, 255, 15);
		send_request(rawt_pkg::CMD_RELEASE, 0, 0, 0);
		send_request(rawt_pkg::CMD_RELEASE, 0, 0, 3);
		send_request(rawt_pkg::CMD_NONE, 31, 255, 15);
		send_request(rawt_pkg::CMD_TICK, 0, 0, 0);
		send_request(rawt_pkg::CMD_TICK, 0, 0, 0);
		send_request(rawt_pkg::CMD_TICK, 0, 0, 0);
		send_request(rawt_pkg::CMD_RELEASE, 0, 0, 3);
		send_request(rawt_pkg::CMD_RELEASE, 0, 0, 3);
		send_request(rawt_pkg::CMD_RELEASE, 0, 0, 15);
		send_request(rawt_pkg::CMD_REQUEST, 7, 0, 0);
		wait_drained();
	endtask

	task automatic test_mass_timeout();
		for (int i = 0; i < NCLIENT; i++) send_request(rawt_pkg::CMD_REQUEST, i, 0, 0);
		send_request(rawt_pkg::CMD_TICK, 0, 0, 0);
		wait_drained();
		for (int i = 1; i < NRES; i++) send_request(rawt_pkg::CMD_RELEASE, 0, 0, i);
		wait_drained();
	endtask

	task automatic test_backpressure();
		hold_cycles = 300;
		send_random(60, 45);
		wait_drained();
	endtask

	task automatic test_random();
		send_random(120, 55);
		wait_drained();
		send_random(120, 35);
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		error_count = 0;
		hold_cycles = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_mass_timeout();
		test_backpressure();
		test_random();
		wait_drained();
		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				m_tready <= 1'b0;
				hold_cycles--;
			end else begin
				case ($urandom_range(0, 7))
					0, 1: m_tready <= 1'b0;
					default: m_tready <= 1'b1;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		alloc_result_t exp_r;
		rawt_pkg::res_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.client_res = m_tdata[4:0];
			got.granted_resource = m_tdata[8:5];
			got.status = m_tuser;
			got.last = m_tlast;
			if (pending_results.size() == 0) begin
				$error("unexpected result client_res=%0d", got.client_res);
				error_count++;
			end else begin
				exp_r = pending_results.pop_front();
				if (got.client_res !== exp_r.client) begin
					$error("client_res expected %0d actual %0d", exp_r.client, got.client_res);
					error_count++;
				end
				if (got.granted_resource !== exp_r.granted) begin
					$error("granted_resource expected %0d actual %0d",
						exp_r.granted, got.granted_resource);
					error_count++;
				end
				if (got.status !== exp_r.status) begin
					$error("status expected %0d actual %0d", exp_r.status, got.status);
					error_count++;
				end
				if (got.last !== exp_r.last) begin
					$error("last expected %0d actual %0d", exp_r.last, got.last);
					error_count++;
				end
			end
		end
	end

	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count >= CYCLE_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

endmodule
